@@ rtl/serial_byte_fifo_with_flush_timeout_defines.svh @@
// ---------------------------------------------------------------------------
// Serial byte FIFO assertion macros
// Shared property wrappers for the serial byte FIFO, clocked on clk and
// disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef SERIAL_BYTE_FIFO_WITH_FLUSH_TIMEOUT_DEFINES_SVH
`define SERIAL_BYTE_FIFO_WITH_FLUSH_TIMEOUT_DEFINES_SVH

// Same-cycle implication
`define SBFF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SBFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sbff_pkg.sv @@
// ---------------------------------------------------------------------------
// Serial byte FIFO package
// Operation codes, result kinds, command and result types and defaults.
// ---------------------------------------------------------------------------
package sbff_pkg;

  localparam int RX_DEPTH_DEFAULT = 128;
  localparam int TX_DEPTH_DEFAULT = 64;

  localparam int ELAPSED_W = 20;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [ELAPSED_W-1:0] FLUSH_TIMEOUT_RESET = ELAPSED_W'(500 * 1000);

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  localparam logic [2:0] OP_RX_PUSH  = 3'd0;
  localparam logic [2:0] OP_RX_READ  = 3'd1;
  localparam logic [2:0] OP_RX_PEEK  = 3'd2;
  localparam logic [2:0] OP_TX_WRITE = 3'd3;
  localparam logic [2:0] OP_TX_FLUSH = 3'd4;
  localparam logic [2:0] OP_TICK     = 3'd5;

  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_RX_DATA = 2'd1;
  localparam logic [1:0] KIND_TX_BYTE = 2'd2;

  typedef enum logic [2:0] {
    CMD_RX_PUSH,
    CMD_RX_READ,
    CMD_RX_PEEK,
    CMD_TX_WRITE,
    CMD_TX_FLUSH,
    CMD_TICK,
    CMD_NOP
  } cmd_cls_t;

  typedef struct packed {
    cmd_cls_t    cls;
    logic [7:0]  data;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       data_valid;
    logic       accepted;
    logic [6:0] rx_count;
    logic [5:0] tx_count;
    logic       last;
  } res_t;

endpackage

@@ rtl/sbff_ram.sv @@
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module sbff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/sbff_front.sv @@
// ---------------------------------------------------------------------------
// Serial byte FIFO front end
// Accept transactions, classify the operation code and queue commands.
// ---------------------------------------------------------------------------
module sbff_front
  import sbff_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [2:0] operation,
  input  logic [7:0] data_byte,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_take
);

  cmd_t               q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_AW:0]   count;
  logic               accept;
  cmd_cls_t           cls;

  assign full      = (count == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];
  assign accept    = push && !full;

  always_comb begin
    unique case (operation)
      OP_RX_PUSH:  cls = CMD_RX_PUSH;
      OP_RX_READ:  cls = CMD_RX_READ;
      OP_RX_PEEK:  cls = CMD_RX_PEEK;
      OP_TX_WRITE: cls = CMD_TX_WRITE;
      OP_TX_FLUSH: cls = CMD_TX_FLUSH;
      OP_TICK:     cls = CMD_TICK;
      default:     cls = CMD_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= '{cls: cls, data: data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (accept && !cmd_take) begin
        count <= count + 1'b1;
      end else if (!accept && cmd_take) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/sbff_back.sv @@
// ---------------------------------------------------------------------------
// Serial byte FIFO back end
// Execute queued commands on the receive and transmit rings, drain frames
// and hold the result register.
// ---------------------------------------------------------------------------
`include "serial_byte_fifo_with_flush_timeout_defines.svh"

module sbff_back
  import sbff_pkg::*;
#(
  parameter int RX_DEPTH = RX_DEPTH_DEFAULT,
  parameter int TX_DEPTH = TX_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [ELAPSED_W-1:0] cfg_wdata,
  input  logic                 cmd_valid,
  input  cmd_t                 cmd,
  output logic                 cmd_take,
  input  logic                 pop,
  output logic                 empty,
  output res_t                 res
);

  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RX_WAIT,
    S_DRAIN_RD,
    S_DRAIN_OUT
  } state_t;

  state_t               state, state_next;
  logic [RX_AW-1:0]     rx_head, rx_head_next, rx_tail, rx_tail_next, rx_tail_inc;
  logic [RX_AW-1:0]     rx_used_next;
  logic [TX_AW-1:0]     tx_head, tx_head_next, tx_tail, tx_tail_next;
  logic [TX_AW-1:0]     tx_tail_inc, tx_head_inc, tx_used_after, tx_used_next;
  logic [TX_AW-1:0]     tx_raddr;
  logic [ELAPSED_W-1:0] elapsed, elapsed_next, elapsed_eff, flush_timeout;
  logic                 drain_acc, drain_acc_next;
  logic                 consume, consume_next;
  logic                 out_valid, out_free, load;
  logic                 rx_full, rx_empty, tx_full, tx_empty;
  logic                 rx_we, rx_re, tx_we, tx_re;
  logic [7:0]           rx_rdata, tx_rdata;
  logic                 frame_end;
  res_t                 ld;

  sbff_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_tail),
    .wdata (cmd.data),
    .re    (rx_re),
    .raddr (rx_head),
    .rdata (rx_rdata)
  );

  sbff_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_tail),
    .wdata (cmd.data),
    .re    (tx_re),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  assign rx_tail_inc   = rx_tail + 1'b1;
  assign tx_tail_inc   = tx_tail + 1'b1;
  assign tx_head_inc   = tx_head + 1'b1;
  assign rx_full       = (rx_tail_inc == rx_head);
  assign rx_empty      = (rx_tail == rx_head);
  assign tx_full       = (tx_tail_inc == tx_head);
  assign tx_empty      = (tx_tail == tx_head);
  assign tx_used_after = tx_tail_inc - tx_head;
  assign elapsed_eff   = tx_empty ? '0 : elapsed;
  assign out_free      = !out_valid || pop;
  assign empty         = !out_valid;
  assign frame_end     = load && ld.kind == KIND_TX_BYTE && ld.last;

  always_comb begin
    state_next     = state;
    rx_head_next   = rx_head;
    rx_tail_next   = rx_tail;
    tx_head_next   = tx_head;
    tx_tail_next   = tx_tail;
    elapsed_next   = elapsed;
    drain_acc_next = drain_acc;
    consume_next   = consume;
    cmd_take       = 1'b0;
    rx_we          = 1'b0;
    rx_re          = 1'b0;
    tx_we          = 1'b0;
    tx_re          = 1'b0;
    tx_raddr       = tx_head;
    load           = 1'b0;
    ld             = '0;
    ld.kind        = KIND_STATUS;
    ld.last        = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_take = 1'b1;
          unique case (cmd.cls) inside
            CMD_RX_PUSH: begin
              load = 1'b1;
              if (!rx_full) begin
                rx_we        = 1'b1;
                rx_tail_next = rx_tail_inc;
                ld.accepted  = 1'b1;
              end
            end
            CMD_RX_READ, CMD_RX_PEEK: begin
              if (rx_empty) begin
                load    = 1'b1;
                ld.kind = KIND_RX_DATA;
              end else begin
                rx_re        = 1'b1;
                consume_next = (cmd.cls == CMD_RX_READ);
                state_next   = S_RX_WAIT;
              end
            end
            CMD_TX_WRITE: begin
              elapsed_next = elapsed_eff;
              if (tx_full) begin
                load = 1'b1;
              end else begin
                tx_we        = 1'b1;
                tx_tail_next = tx_tail_inc;
                if (tx_used_after == TX_AW'(TX_DEPTH - 1) || elapsed_eff > flush_timeout) begin
                  drain_acc_next = 1'b1;
                  state_next     = S_DRAIN_RD;
                end else begin
                  load        = 1'b1;
                  ld.accepted = 1'b1;
                end
              end
            end
            CMD_TX_FLUSH: begin
              if (!tx_empty) begin
                drain_acc_next = 1'b0;
                state_next     = S_DRAIN_RD;
              end else begin
                elapsed_next = '0;
                load         = 1'b1;
              end
            end
            CMD_TICK: begin
              load = 1'b1;
              if (elapsed != ELAPSED_MAX) begin
                elapsed_next = elapsed + 1'b1;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_RX_WAIT: begin
        if (out_free) begin
          load          = 1'b1;
          ld.kind       = KIND_RX_DATA;
          ld.out_byte   = rx_rdata;
          ld.data_valid = 1'b1;
          if (consume) begin
            rx_head_next = rx_head + 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      S_DRAIN_RD: begin
        tx_re      = 1'b1;
        state_next = S_DRAIN_OUT;
      end
      S_DRAIN_OUT: begin
        if (out_free) begin
          load          = 1'b1;
          ld.kind       = KIND_TX_BYTE;
          ld.out_byte   = tx_rdata;
          ld.data_valid = 1'b1;
          ld.accepted   = drain_acc;
          ld.last       = (tx_head_inc == tx_tail);
          tx_head_next  = tx_head_inc;
          if (ld.last) begin
            elapsed_next = '0;
            state_next   = S_IDLE;
          end else begin
            tx_re    = 1'b1;
            tx_raddr = tx_head_inc;
          end
        end
      end
    endcase

    rx_used_next = rx_tail_next - rx_head_next;
    tx_used_next = tx_tail_next - tx_head_next;
    ld.rx_count  = 7'(rx_used_next);
    ld.tx_count  = 6'(tx_used_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rx_head       <= '0;
      rx_tail       <= '0;
      tx_head       <= '0;
      tx_tail       <= '0;
      elapsed       <= '0;
      flush_timeout <= FLUSH_TIMEOUT_RESET;
      drain_acc     <= 1'b0;
      consume       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state     <= state_next;
      rx_head   <= rx_head_next;
      rx_tail   <= rx_tail_next;
      tx_head   <= tx_head_next;
      tx_tail   <= tx_tail_next;
      elapsed   <= elapsed_next;
      drain_acc <= drain_acc_next;
      consume   <= consume_next;
      if (cfg_wen) begin
        flush_timeout <= cfg_wdata;
      end
      if (load) begin
        out_valid <= 1'b1;
        res       <= ld;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SBFF_ASSERT_NOW(a_rx_no_overrun, rx_we, !rx_full, "receive ring written while full")
  `SBFF_ASSERT_NOW(a_drain_nonempty, state == S_DRAIN_OUT, !tx_empty, "drain on empty ring")
  `SBFF_ASSERT_NOW(a_no_overwrite, load, out_free, "result register overwritten")
  `SBFF_ASSERT_NEXT(a_drain_end, frame_end, tx_empty && elapsed == '0, "frame end not clean")

endmodule

@@ rtl/serial_byte_fifo_with_flush_timeout.sv @@
// ---------------------------------------------------------------------------
// Serial byte FIFO with flush timeout
// Receive and transmit byte rings with transmit coalescing on a tick timeout.
// ---------------------------------------------------------------------------
// Input channel: push/full with operation and data_byte. Commands enter a
// four-entry command queue, so up to four transactions are taken while the
// back end is busy or the result side stalls.
// Result channel: empty/pop; the oldest result sits on the result ports while
// empty is low. Every transaction gives at least one result; the final one of
// a transaction carries last.
// Timing: status results pass through the command queue and the result
// register; receive read and peek results on a non-empty ring also pass the
// registered RAM read. A transmit drain holds the back end for the write or
// flush, S_DRAIN_RD that opens the transmit RAM read, then S_DRAIN_OUT at one
// byte per cycle while pop keeps up, via the registered RAM read port.
// Throughput: one status transaction per cycle while pop keeps up.
// A stalled receiver holds the result register and freezes the back end; the
// command queue then fills and full rises.
// Reset (rst, synchronous): rings empty, timer zero, timeout 500000 ticks,
// command queue and result register empty. RAM contents are left as they are.
// ---------------------------------------------------------------------------
module serial_byte_fifo_with_flush_timeout
  import sbff_pkg::*;
#(
  parameter int RX_DEPTH = RX_DEPTH_DEFAULT,
  parameter int TX_DEPTH = TX_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [ELAPSED_W-1:0] cfg_wdata,
  input  logic                 push,
  output logic                 full,
  input  logic [2:0]           operation,
  input  logic [7:0]           data_byte,
  output logic                 empty,
  input  logic                 pop,
  output logic [1:0]           kind,
  output logic [7:0]           out_byte,
  output logic                 data_valid,
  output logic                 accepted,
  output logic [6:0]           rx_count,
  output logic [5:0]           tx_count,
  output logic                 last
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;
  res_t res;

  sbff_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .operation (operation),
    .data_byte (data_byte),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  sbff_back #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  assign kind       = res.kind;
  assign out_byte   = res.out_byte;
  assign data_valid = res.data_valid;
  assign accepted   = res.accepted;
  assign rx_count   = res.rx_count;
  assign tx_count   = res.tx_count;
  assign last       = res.last;

endmodule

@@ dv/serial_byte_fifo_with_flush_timeout_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Serial byte FIFO with flush timeout: self-checking testbench
// Drives receive and transmit byte-ring commands through the push/full port
// and pops results through empty/pop, with random gaps on both sides and a
// long result stall that backs the command queue up. A scoreboard class
// mirrors both rings, the tick timer and the timeout register, predicts
// every result of each transaction and compares popped results field by
// field, oldest first. Runs several timeout settings, 0 and full scale too.
// ---------------------------------------------------------------------------
module serial_byte_fifo_with_flush_timeout_tb;
  import sbff_pkg::*;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int HOLD_CYCLES = 250;
  localparam int STALL_LIMIT = 3000;
  localparam logic [ELAPSED_W-1:0] TIMEOUT_MAX = '1;

  class sbff_scoreboard;
    bit [7:0] rx_mem [RX_DEPTH_DEFAULT];
    bit [7:0] tx_mem [TX_DEPTH_DEFAULT];
    bit [6:0] rx_rd, rx_wr;
    bit [5:0] tx_rd, tx_wr;
    bit [ELAPSED_W-1:0] ticks, timeout;
    res_t due[$];
    int errors;

    function new();
      timeout = FLUSH_TIMEOUT_RESET;
    endfunction

    function void set_timeout(logic [ELAPSED_W-1:0] value);
      timeout = value;
    endfunction

    function void queue_result(logic [1:0] k, logic [7:0] b, logic v, logic acc, logic lst);
      res_t r;
      r.kind       = k;
      r.out_byte   = b;
      r.data_valid = v;
      r.accepted   = acc;
      r.rx_count   = rx_wr - rx_rd;
      r.tx_count   = tx_wr - tx_rd;
      r.last       = lst;
      due.push_back(r);
    endfunction

    function void drain_frame(logic acc);
      bit [7:0] b;
      while (tx_rd != tx_wr) begin
        b = tx_mem[tx_rd];
        tx_rd++;
        queue_result(KIND_TX_BYTE, b, 1'b1, acc, tx_rd == tx_wr);
      end
      ticks = '0;
    endfunction

    function void note_input(logic [2:0] op, logic [7:0] d);
      bit [6:0] rx_next;
      bit [5:0] tx_next;
      bit [5:0] tx_held;
      case (op) inside
        OP_RX_PUSH: begin
          rx_next = rx_wr + 7'd1;
          if (rx_next != rx_rd) begin
            rx_mem[rx_wr] = d;
            rx_wr = rx_next;
            queue_result(KIND_STATUS, 8'h00, 1'b0, 1'b1, 1'b1);
          end else begin
            queue_result(KIND_STATUS, 8'h00, 1'b0, 1'b0, 1'b1);
          end
        end
        OP_RX_READ, OP_RX_PEEK: begin
          if (rx_rd != rx_wr) begin
            d = rx_mem[rx_rd];
            if (op == OP_RX_READ) rx_rd++;
            queue_result(KIND_RX_DATA, d, 1'b1, 1'b0, 1'b1);
          end else begin
            queue_result(KIND_RX_DATA, 8'h00, 1'b0, 1'b0, 1'b1);
          end
        end
        OP_TX_WRITE: begin
          if (tx_wr == tx_rd) ticks = '0;
          tx_next = tx_wr + 6'd1;
          if (tx_next == tx_rd) begin
            queue_result(KIND_STATUS, 8'h00, 1'b0, 1'b0, 1'b1);
          end else begin
            tx_mem[tx_wr] = d;
            tx_wr = tx_next;
            tx_held = tx_wr - tx_rd;
            if (tx_held == 6'(TX_DEPTH_DEFAULT - 1) || ticks > timeout) begin
              drain_frame(1'b1);
            end else begin
              queue_result(KIND_STATUS, 8'h00, 1'b0, 1'b1, 1'b1);
            end
          end
        end
        OP_TX_FLUSH: begin
          if (tx_rd != tx_wr) begin
            drain_frame(1'b0);
          end else begin
            ticks = '0;
            queue_result(KIND_STATUS, 8'h00, 1'b0, 1'b0, 1'b1);
          end
        end
        OP_TICK: begin
          if (ticks != ELAPSED_MAX) ticks++;
          queue_result(KIND_STATUS, 8'h00, 1'b0, 1'b0, 1'b1);
        end
        default: begin
          queue_result(KIND_STATUS, 8'h00, 1'b0, 1'b0, 1'b1);
        end
      endcase
    endfunction

    function void report(string field, int exp_val, int act_val);
      $display("%0t: %s expected %0d, got %0d", $time, field, exp_val, act_val);
      errors++;
    endfunction

    function void check_result(res_t got);
      res_t exp_res;
      if (due.size() == 0) begin
        $display("%0t: result with nothing outstanding, got %p", $time, got);
        errors++;
        return;
      end
      exp_res = due.pop_front();
      if (got.kind !== exp_res.kind) report("kind", exp_res.kind, got.kind);
      if (got.out_byte !== exp_res.out_byte) report("out_byte", exp_res.out_byte, got.out_byte);
      if (got.data_valid !== exp_res.data_valid)
        report("data_valid", exp_res.data_valid, got.data_valid);
      if (got.accepted !== exp_res.accepted) report("accepted", exp_res.accepted, got.accepted);
      if (got.rx_count !== exp_res.rx_count) report("rx_count", exp_res.rx_count, got.rx_count);
      if (got.tx_count !== exp_res.tx_count) report("tx_count", exp_res.tx_count, got.tx_count);
      if (got.last !== exp_res.last) report("last", exp_res.last, got.last);
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [ELAPSED_W-1:0] cfg_wdata = '0;
  logic push = 1'b0;
  logic full;
  logic [2:0] operation = OP_RX_PUSH;
  logic [7:0] data_byte = '0;
  logic empty;
  logic pop = 1'b0;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic data_valid;
  logic accepted;
  logic [6:0] rx_count;
  logic [5:0] tx_count;
  logic last;

  sbff_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_request = 1'b0;
  int items_sent = 0;
  int idle_cycles = 0;

  serial_byte_fifo_with_flush_timeout i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .push       (push),
    .full       (full),
    .operation  (operation),
    .data_byte  (data_byte),
    .empty      (empty),
    .pop        (pop),
    .kind       (kind),
    .out_byte   (out_byte),
    .data_valid (data_valid),
    .accepted   (accepted),
    .rx_count   (rx_count),
    .tx_count   (tx_count),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side
  initial begin
    res_t got;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got.kind       = kind;
        got.out_byte   = out_byte;
        got.data_valid = data_valid;
        got.accepted   = accepted;
        got.rx_count   = rx_count;
        got.tx_count   = tx_count;
        got.last       = last;
        sb.check_result(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        pop <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        pop <= 1'b1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_op(input logic [2:0] op, input logic [7:0] d);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    push      <= 1'b1;
    operation <= op;
    data_byte <= d;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_input(op, d);
    items_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [ELAPSED_W-1:0] value);
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.set_timeout(value);
  endtask

  task automatic run_sequence();
    int n;
    case ($urandom_range(0, 9))
      0, 1: begin
        n = ($urandom_range(0, 9) == 0) ? RX_DEPTH_DEFAULT + 2 : $urandom_range(1, 20);
        repeat (n) send_op(OP_RX_PUSH, 8'($urandom));
      end
      2, 3: begin
        n = $urandom_range(1, 20);
        repeat (n) send_op(($urandom_range(0, 2) == 0) ? OP_RX_PEEK : OP_RX_READ, 8'($urandom));
      end
      4, 5, 6: begin
        n = $urandom_range(1, TX_DEPTH_DEFAULT + 6);
        repeat (n) begin
          send_op(OP_TX_WRITE, 8'($urandom));
          if ($urandom_range(0, 5) == 0) send_op(OP_TICK, 8'($urandom));
        end
      end
      7: send_op(OP_TX_FLUSH, 8'($urandom));
      8: repeat ($urandom_range(1, 8)) send_op(OP_TICK, 8'($urandom));
      default: repeat ($urandom_range(1, 6)) send_op(3'($urandom_range(0, 7)), 8'($urandom));
    endcase
  endtask

  task automatic run_phase(input int quota);
    int stop_at;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) run_sequence();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_op(OP_RX_READ, 8'hFF);
    send_op(OP_RX_PEEK, 8'h00);
    send_op(OP_RX_PUSH, 8'h00);
    send_op(OP_RX_PUSH, 8'hFF);
    send_op(OP_RX_PEEK, 8'h5A);
    send_op(OP_RX_READ, 8'h00);
    send_op(OP_RX_READ, 8'h00);
    send_op(OP_RX_READ, 8'h00);
    send_op(OP_TX_FLUSH, 8'hFF);
    send_op(OP_TX_WRITE, 8'h00);
    send_op(OP_TX_WRITE, 8'hFF);
    send_op(OP_TICK, 8'h00);
    send_op(OP_TX_FLUSH, 8'h00);
    send_op(OP_SPARE_6, 8'hFF);
    send_op(OP_SPARE_7, 8'hA5);
    send_op(OP_TICK, 8'hFF);

    write_timeout('0);
    send_op(OP_TX_WRITE, 8'h12);
    send_op(OP_TICK, 8'h00);
    send_op(OP_TX_WRITE, 8'h34);
    run_phase(40);

    write_timeout(TIMEOUT_MAX);
    hold_request = 1'b1;
    run_phase(60);

    write_timeout(ELAPSED_W'($urandom_range(1, 6)));
    run_phase(40);

    write_timeout(ELAPSED_W'($urandom_range(0, 1048575)));
    run_phase(30);

    write_timeout(ELAPSED_W'(2));
    wait_drained();
    quiet = 1'b1;
    run_phase(30);

    wait_drained();
    repeat (TX_DEPTH_DEFAULT + 8) @(posedge clk);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ serial_byte_fifo_with_flush_timeout.f @@
+incdir+rtl
rtl/sbff_pkg.sv
rtl/sbff_ram.sv
rtl/sbff_front.sv
rtl/sbff_back.sv
rtl/serial_byte_fifo_with_flush_timeout.sv
dv/serial_byte_fifo_with_flush_timeout_tb.sv
